### hw/rtl/jesc_pkg.sv
// ----------------------------------------------------------------------------
// jesc_pkg
// Shared types and constants for the Julia escape-time pixel core.
// ----------------------------------------------------------------------------
package jesc_pkg;

	localparam int FRAC_BITS   = 24;
	localparam int WIDTH_DEF   = 96;
	localparam int HEIGHT_DEF  = 64;
	localparam int COL_W       = 7;
	localparam int ROW_W       = 6;
	localparam int Q_W         = 32;
	localparam int LIMIT_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd2;

	localparam logic [Q_W-1:0]     C_REAL_RST = 32'hFF33_3334; // -0.8
	localparam logic [Q_W-1:0]     C_IMAG_RST = 32'h0027_EF9D; // 0.156
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 8'd100;

	localparam logic [Q_W-1:0] ESCAPE_BOUND = 32'h0400_0000; // 4.0
	localparam logic [Q_W-1:0] RE_MIN       = 32'hFE80_0000; // -1.5
	localparam logic [Q_W-1:0] IM_MIN       = 32'hFF00_0000; // -1.0

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic [Q_W-1:0]   zr;
		logic [Q_W-1:0]   zi;
	} job_t;

	typedef struct packed {
		logic [Q_W-1:0]     c_real;
		logic [Q_W-1:0]     c_imag;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR_RE,
		ST_SQR_IM,
		ST_CROSS,
		ST_UPDATE,
		ST_FINISH
	} eng_state_t;

endpackage

### hw/rtl/jesc_front.sv
// ----------------------------------------------------------------------------
// jesc_front
// Takes a pixel request, maps it to its starting z and mirrored column.
// ----------------------------------------------------------------------------
module jesc_front import jesc_pkg::*; #(
	parameter int WIDTH  = WIDTH_DEF,
	parameter int HEIGHT = HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [COL_W-1:0] pixel_x,
	input  logic [ROW_W-1:0] pixel_y,
	output logic             job_valid,
	input  logic             job_ready,
	output job_t             job
);

	localparam logic [Q_W-1:0]   STEP_RE = Q_W'((64'd3 << FRAC_BITS) / (WIDTH - 1));
	localparam logic [Q_W-1:0]   STEP_IM = Q_W'((64'd2 << FRAC_BITS) / (HEIGHT - 1));
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(WIDTH - 1);

	logic [Q_W-1:0] re_off;
	logic [Q_W-1:0] im_off;
	job_t           job_s1;
	logic           valid_s1;

	assign re_off = Q_W'({{(Q_W-COL_W){1'b0}}, pixel_x} * STEP_RE);
	assign im_off = Q_W'({{(Q_W-ROW_W){1'b0}}, pixel_y} * STEP_IM);

	assign in_ready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s1.column <= COL_MAX - pixel_x;
			job_s1.row    <= pixel_y;
			job_s1.zr     <= re_off + RE_MIN;
			job_s1.zi     <= im_off + IM_MIN;
		end
	end

endmodule

### hw/rtl/jesc_queue.sv
// ----------------------------------------------------------------------------
// jesc_queue
// Small FIFO of mapped pixel jobs between the front and the iteration engine.
// ----------------------------------------------------------------------------
module jesc_queue import jesc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_job,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_job
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = count_q != CNT_FULL;
	assign rd_valid = count_q != '0;
	assign rd_job   = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

### hw/rtl/jesc_engine.sv
// ----------------------------------------------------------------------------
// jesc_engine
// Iterates z = z^2 + c on one shared 32x32 multiplier, three products per
// iteration, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module jesc_engine import jesc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             job_valid,
	output logic             job_ready,
	input  job_t             job,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [COL_W-1:0] column,
	output logic [ROW_W-1:0] row,
	output logic             lit
);

	eng_state_t              state_q;
	eng_state_t              state_d;
	logic [Q_W-1:0]          zr_q;
	logic [Q_W-1:0]          zi_q;
	logic [Q_W-1:0]          zr2_q;
	logic [Q_W-1:0]          zi2_q;
	logic signed [2*Q_W-1:0] prod_q;
	logic [LIMIT_W-1:0]      it_q;
	logic                    lit_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic                    out_valid_q;
	logic [COL_W-1:0]        out_col_q;
	logic [ROW_W-1:0]        out_row_q;
	logic                    out_lit_q;

	logic signed [Q_W-1:0] mul_a;
	logic signed [Q_W-1:0] mul_b;
	logic [Q_W-1:0]        prod_q24;
	logic [Q_W-1:0]        mag;
	logic [LIMIT_W-1:0]    it_next;
	logic                  escaped;
	logic                  last_iter;
	logic                  slot_free;
	logic                  load_job;

	assign prod_q24  = prod_q[FRAC_BITS+Q_W-1:FRAC_BITS];
	assign mag       = zr2_q + zi2_q;
	assign escaped   = $signed(mag) > $signed(ESCAPE_BOUND);
	assign it_next   = it_q + 1'b1;
	assign last_iter = it_next == cfg.limit;
	assign slot_free = !out_valid_q || out_ready;
	assign job_ready = state_q == ST_IDLE;
	assign load_job  = job_valid && job_ready;

	assign out_valid = out_valid_q;
	assign column    = out_col_q;
	assign row       = out_row_q;
	assign lit       = out_lit_q;

	always_comb begin
		unique case (state_q)
			ST_SQR_RE: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			ST_SQR_IM: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = (cfg.limit == '0) ? ST_FINISH : ST_SQR_RE;
				end
			end
			ST_SQR_RE: state_d = ST_SQR_IM;
			ST_SQR_IM: state_d = ST_CROSS;
			ST_CROSS:  state_d = ST_UPDATE;
			ST_UPDATE: begin
				state_d = (escaped || last_iter) ? ST_FINISH : ST_SQR_RE;
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (load_job) begin
			zr_q  <= job.zr;
			zi_q  <= job.zi;
			col_q <= job.column;
			row_q <= job.row;
			it_q  <= '0;
			lit_q <= 1'b1;
		end
		if (state_q == ST_SQR_IM) begin
			zr2_q <= prod_q24;
		end
		if (state_q == ST_CROSS) begin
			zi2_q <= prod_q24;
		end
		if (state_q == ST_UPDATE) begin
			if (escaped) begin
				lit_q <= 1'b0;
			end else begin
				zr_q <= zr2_q - zi2_q + cfg.c_real;
				zi_q <= {prod_q24[Q_W-2:0], 1'b0} + cfg.c_imag;
				it_q <= it_next;
			end
		end
		if (state_q == ST_FINISH && slot_free) begin
			out_col_q <= col_q;
			out_row_q <= row_q;
			out_lit_q <= lit_q;
		end
	end

endmodule

### hw/rtl/julia_escape_pixel_core.sv
// ----------------------------------------------------------------------------
// julia_escape_pixel_core
// Julia-set escape-time test for one display pixel per request.
// ----------------------------------------------------------------------------
// A pixel request is mapped to its starting z in a registered front stage
// and waits in a two-entry queue; the engine then iterates z = z^2 + c on
// one shared 32x32 multiplier that forms re^2, im^2 and re*im in turn.
// New requests are taken while the engine works or a result waits, until
// the front stage and the queue are full. Write configuration only while
// idle.
module julia_escape_pixel_core import jesc_pkg::*; #(
	parameter int WIDTH  = WIDTH_DEF,
	parameter int HEIGHT = HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [COL_W-1:0]     pixel_x,
	input  logic [ROW_W-1:0]     pixel_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COL_W-1:0]     column,
	output logic [ROW_W-1:0]     row,
	output logic                 lit
);

	cfg_t cfg_q;
	logic front_valid;
	logic front_ready;
	job_t front_job;
	logic q_valid;
	logic q_ready;
	job_t q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real <= C_REAL_RST;
			cfg_q.c_imag <= C_IMAG_RST;
			cfg_q.limit  <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_C_REAL:     cfg_q.c_real <= cfg_data;
				REG_C_IMAG:     cfg_q.c_imag <= cfg_data;
				REG_ITER_LIMIT: cfg_q.limit  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	jesc_front #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job       (front_job)
	);

	jesc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_job   (front_job),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_job   (q_job)
	);

	jesc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.column    (column),
		.row       (row),
		.lit       (lit)
	);

endmodule

### hw/rtl/jesc_checker.sv
// ----------------------------------------------------------------------------
// jesc_checker
// Port-level checks on the pixel core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module jesc_checker import jesc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [COL_W-1:0] column,
	input logic [ROW_W-1:0] row,
	input logic             lit
);

	// front stage, queue, engine and output register
	localparam int         CAPACITY = QUEUE_DEPTH + 3;
	localparam int         PEND_W   = $clog2(CAPACITY + 2);
	localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(CAPACITY);

	logic [PEND_W-1:0] pending_q;
	logic              in_acc;
	logic              out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column) && $stable(row)
			&& $stable(lit))
		else $error("result changed or dropped while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without an outstanding request");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PEND_MAX)
		else $error("more requests in flight than the core can hold");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == '0 |-> in_ready)
		else $error("empty core refuses a request");

endmodule

bind julia_escape_pixel_core jesc_checker u_jesc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.column    (column),
	.row       (row),
	.lit       (lit)
);

### bench/tb_julia_escape_pixel_core.sv
// ----------------------------------------------------------------------------
// tb_julia_escape_pixel_core
// Self-checking bench for the Julia escape-time pixel core.
// ----------------------------------------------------------------------------
// A short scripted sequence covers the corner pixels, pixels past the screen
// edge and the limit and constant extremes. It is followed by phases of
// random pixels, each with its own constant and iteration limit. Every
// accepted pixel request gets an escape-time prediction or a known value,
// and each result is checked against the oldest expected one. Both handshake
// sides throttle at random, and one phase holds the result side off long
// enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_julia_escape_pixel_core import jesc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_PHASES    = 15;
	localparam int PHASE_ITEMS = 114;
	localparam int DEEP_ITEMS  = 40;
	localparam int RX_HOLD     = 2000;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL        = 50;
	localparam int SCRIPT_LEN  = 31;
	localparam int MAX_REPORTS = 200;

	localparam logic [Q_W-1:0] STEP_RE = Q_W'((3 << FRAC_BITS) / (WIDTH_DEF - 1));
	localparam logic [Q_W-1:0] STEP_IM = Q_W'((2 << FRAC_BITS) / (HEIGHT_DEF - 1));

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             lit;
	} pixel_result_t;

	typedef enum logic [1:0] {
		OP_PREDICT,
		OP_KNOWN,
		OP_REG
	} script_op_t;

	typedef struct packed {
		script_op_t           op;
		logic [CFG_IDX_W-1:0] idx;
		logic [Q_W-1:0]       data;
		logic [COL_W-1:0]     px;
		logic [ROW_W-1:0]     py;
		pixel_result_t        known;
	} script_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_C_REAL;
	logic [Q_W-1:0]       cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [COL_W-1:0]     pixel_x   = '0;
	logic [ROW_W-1:0]     pixel_y   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COL_W-1:0]     column;
	logic [ROW_W-1:0]     row;
	logic                 lit;

	cfg_t          julia_cfg = '{c_real: C_REAL_RST, c_imag: C_IMAG_RST, limit: LIMIT_RST};
	pixel_result_t awaited_pixels [$];
	script_row_t   script [SCRIPT_LEN];
	int            mismatches       = 0;
	int            tx_idle_pct      = 0;
	int            rx_idle_pct      = 0;
	int            rx_hold_requests = 0;
	int            quiet_cycles     = 0;

	julia_escape_pixel_core #(
		.WIDTH (WIDTH_DEF),
		.HEIGHT(HEIGHT_DEF)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.column   (column),
		.row      (row),
		.lit      (lit)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Q7.24 product: full 64-bit product, arithmetic shift, low word kept
	function automatic logic [Q_W-1:0] q_mul(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [2*Q_W-1:0] p;
		logic signed [2*Q_W-1:0] sh;
		p  = a * b;
		sh = p >>> FRAC_BITS;
		return sh[Q_W-1:0];
	endfunction

	function automatic pixel_result_t escape_pixel(input logic [COL_W-1:0] px,
			input logic [ROW_W-1:0] py);
		logic [Q_W-1:0] zr, zi, zr2, zi2, mag, nr;
		int             n;
		logic           escaped;
		pixel_result_t  res;
		zr      = {{(Q_W-COL_W){1'b0}}, px} * STEP_RE + RE_MIN;
		zi      = {{(Q_W-ROW_W){1'b0}}, py} * STEP_IM + IM_MIN;
		n       = 0;
		escaped = 1'b0;
		while (!escaped && n < int'(julia_cfg.limit)) begin
			zr2 = q_mul(zr, zr);
			zi2 = q_mul(zi, zi);
			mag = zr2 + zi2;
			if ($signed(mag) > $signed(ESCAPE_BOUND)) begin
				escaped = 1'b1;
			end else begin
				nr = zr2 - zi2 + julia_cfg.c_real;
				zi = (q_mul(zr, zi) << 1) + julia_cfg.c_imag;
				zr = nr;
				n++;
			end
		end
		res.column = COL_W'(WIDTH_DEF - 1 - int'(px));
		res.row    = py;
		res.lit    = (n == int'(julia_cfg.limit));
		return res;
	endfunction

	function automatic script_row_t pix(input int x, input int y);
		script_row_t r;
		r       = '0;
		r.op    = OP_PREDICT;
		r.px    = COL_W'(x);
		r.py    = ROW_W'(y);
		return r;
	endfunction

	function automatic script_row_t pix_known(input int x, input int y, input int col,
			input int rw, input bit lt);
		script_row_t r;
		r              = pix(x, y);
		r.op           = OP_KNOWN;
		r.known.column = COL_W'(col);
		r.known.row    = ROW_W'(rw);
		r.known.lit    = lt;
		return r;
	endfunction

	function automatic script_row_t reg_wr(input logic [CFG_IDX_W-1:0] idx,
			input logic [Q_W-1:0] data);
		script_row_t r;
		r      = '0;
		r.op   = OP_REG;
		r.idx  = idx;
		r.data = data;
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_C_REAL:     julia_cfg.c_real = data;
			REG_C_IMAG:     julia_cfg.c_imag = data;
			REG_ITER_LIMIT: julia_cfg.limit  = data[LIMIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// drop the request line and wait for every pending pixel to come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_pixels.size() != 0);
	endtask

	task automatic send_pixel(input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y,
			input pixel_result_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= x;
		pixel_y  <= y;
		do @(posedge clk); while (in_ready !== 1'b1);
		awaited_pixels.push_back(want);
	endtask

	task automatic flag_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		pixel_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (awaited_pixels.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result column %0d row %0d lit %0d expected none",
					$time, column, row, lit);
			end else begin
				want = awaited_pixels.pop_front();
				flag_field("column", want.column, column);
				flag_field("row", want.row, row);
				flag_field("lit", want.lit, lit);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random throttle, plus a long hold whenever one is requested
	initial begin : rx_side
		int holds_taken;
		holds_taken = 0;
		forever begin
			@(posedge clk);
			if (holds_taken != rx_hold_requests) begin
				holds_taken = rx_hold_requests;
				out_ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int               i, phase, k, n_items;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		logic [Q_W-1:0]   c_re, c_im;
		logic [Q_W-1:0]   lim;

		tx_idle_pct = 29;
		rx_idle_pct = 87;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		script = '{
			pix_known(0, 0, 95, 0, 0),
			pix_known(95, 63, 0, 63, 0),
			pix_known(127, 0, 96, 0, 0),
			pix(48, 32), pix(96, 31), pix(64, 0), pix(0, 63),
			pix(31, 47), pix(63, 16), pix(1, 1), pix(126, 62),
			reg_wr(REG_ITER_LIMIT, 32'd0),
			pix_known(48, 32, 47, 32, 1),
			pix_known(0, 0, 95, 0, 1),
			pix_known(127, 63, 96, 63, 1),
			reg_wr(REG_C_REAL, 32'h0000_0000),
			reg_wr(REG_C_IMAG, 32'h0000_0000),
			reg_wr(REG_ITER_LIMIT, 32'd255),
			pix(48, 32), pix(20, 40),
			reg_wr(REG_ITER_LIMIT, 32'd1),
			pix(48, 32), pix(0, 0),
			reg_wr(REG_C_REAL, 32'h7FFF_FFFF),
			reg_wr(REG_C_IMAG, 32'h8000_0000),
			reg_wr(REG_ITER_LIMIT, 32'd255),
			pix(48, 32), pix(10, 50),
			reg_wr(REG_C_REAL, 32'h8000_0000),
			reg_wr(REG_C_IMAG, 32'h7FFF_FFFF),
			pix(70, 5)
		};

		for (i = 0; i < SCRIPT_LEN; i++) begin
			case (script[i].op)
				OP_REG: begin
					settle();
					write_reg(script[i].idx, script[i].data);
				end
				OP_KNOWN: send_pixel(script[i].px, script[i].py, script[i].known);
				default:  send_pixel(script[i].px, script[i].py,
					escape_pixel(script[i].px, script[i].py));
			endcase
		end

		for (phase = 0; phase < N_PHASES; phase++) begin
			if (phase < 5) begin
				tx_idle_pct = 29;
				rx_idle_pct = 87;
			end else if (phase < 10) begin
				tx_idle_pct = 87;
				rx_idle_pct = 29;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			// mostly constants near the interesting region, every third one wild
			if (phase % 3 == 0) begin
				c_re = $urandom();
				c_im = $urandom();
			end else begin
				c_re = $urandom_range(32'h0300_0000) - 32'h0180_0000;
				c_im = $urandom_range(32'h0300_0000) - 32'h0180_0000;
			end
			lim     = $urandom_range(64, 1);
			n_items = PHASE_ITEMS;
			case (phase)
				2: lim = 3;
				4: begin
					lim     = 255;
					n_items = DEEP_ITEMS;
				end
				9: lim = 0;
				12: begin
					c_re = C_REAL_RST;
					c_im = C_IMAG_RST;
					lim  = LIMIT_RST;
				end
				default: ;
			endcase

			settle();
			write_reg(REG_C_REAL, c_re);
			write_reg(REG_C_IMAG, c_im);
			write_reg(REG_ITER_LIMIT, lim);

			// back up the request side behind a stalled result side
			if (phase == 2)
				rx_hold_requests++;

			for (k = 0; k < n_items; k++) begin
				if (phase == 7 && k == n_items / 2)
					settle();
				x = ($urandom_range(99) < 85) ? COL_W'($urandom_range(95))
					: COL_W'($urandom_range(127, 96));
				y = ROW_W'($urandom_range(63));
				send_pixel(x, y, escape_pixel(x, y));
			end
		end

		settle();
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
